// ----- sv/ir_range_average_and_linearize_top_defines.svh -----
// assertion macros for the infrared range block
`ifndef IR_RANGE_AVERAGE_AND_LINEARIZE_TOP_DEFINES_SVH
`define IR_RANGE_AVERAGE_AND_LINEARIZE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IRAL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("iral assertion failed");
`define IRAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iral assertion failed");
`else
`define IRAL_ASSERT(lbl, clk, rst_n, prop)
`define IRAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/iral_pkg.sv -----
`timescale 1ns / 1ps

package iral_pkg;

	localparam int CHANNELS     = 8;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WINDOW       = 16;
	localparam int WIN_W        = $clog2(WINDOW);
	localparam int CURVE_POINTS = 30;
	localparam int J_W          = $clog2(CURVE_POINTS);
	localparam int STEP_MM      = 5;

	localparam int CHAN_FW   = 3;
	localparam int SAMPLE_W  = 12;
	localparam int DIST_W    = 8;
	localparam int MASK_W    = 8;
	localparam int SUM_W     = SAMPLE_W + WIN_W;
	localparam int ALU_W     = SUM_W + 1;
	localparam int RAM_AW    = CH_W + WIN_W;
	localparam int RAM_DEPTH = CHANNELS * WINDOW;

	localparam logic [DIST_W-1:0] STEP_D    = DIST_W'(STEP_MM);
	localparam logic [DIST_W-1:0] BEYOND_MM = DIST_W'(CURVE_POINTS * STEP_MM);

	localparam logic CFG_GND_MASK  = 1'b0;
	localparam logic CFG_GND_LEVEL = 1'b1;

	localparam logic [SAMPLE_W-1:0] CURVE [CURVE_POINTS] = '{
		12'd3840, 12'd3835, 12'd3825, 12'd3650, 12'd3300, 12'd2560, 12'd1960, 12'd1530,
		12'd1200, 12'd1000, 12'd870,  12'd750,  12'd600,  12'd520,  12'd450,  12'd400,
		12'd350,  12'd325,  12'd275,  12'd250,  12'd208,  12'd169,  12'd145,  12'd135,
		12'd120,  12'd106,  12'd80,   12'd65,   12'd42,   12'd30
	};

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

endpackage

// ----- sv/iral_alu.sv -----
`timescale 1ns / 1ps

module iral_alu (
	input  iral_pkg::alu_req_t            req,
	output logic [iral_pkg::ALU_W-1:0]    res,
	output logic                          ge
);
	import iral_pkg::*;

	logic [ALU_W:0] full;

	// subtract is a + ~b + 1, carry out means a >= b
	always_comb begin
		full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
			+ {{ALU_W{1'b0}}, req.sub};
	end

	assign res = full[ALU_W-1:0];
	assign ge  = full[ALU_W];

endmodule

// ----- sv/iral_ring_ram.sv -----
`timescale 1ns / 1ps

module iral_ring_ram (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [iral_pkg::RAM_AW-1:0]    addr,
	input  logic [iral_pkg::SAMPLE_W-1:0]  wdata,
	output logic [iral_pkg::SAMPLE_W-1:0]  rdata
);
	import iral_pkg::*;

	logic [SAMPLE_W-1:0] mem [RAM_DEPTH];
	logic [SAMPLE_W-1:0] mem_rd_q;
	logic [RAM_DEPTH-1:0] vld_q;
	logic                 vld_rd_q;

	// read returns the old entry, then the new sample replaces it
	always_ff @(posedge clk) begin
		if (en) begin
			mem_rd_q  <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else if (en) begin
			vld_rd_q    <= vld_q[addr];
			vld_q[addr] <= 1'b1;
		end
	end

	assign rdata = vld_rd_q ? mem_rd_q : '0;

endmodule

// ----- sv/iral_core.sv -----
`timescale 1ns / 1ps
`include "ir_range_average_and_linearize_top_defines.svh"

module iral_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [iral_pkg::CHAN_FW-1:0]    in_ch,
	input  logic [iral_pkg::SAMPLE_W-1:0]   in_raw,
	input  logic [iral_pkg::MASK_W-1:0]     gnd_mask,
	input  logic [iral_pkg::SAMPLE_W-1:0]   gnd_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [iral_pkg::CHAN_FW-1:0]    out_ch,
	output logic [iral_pkg::SAMPLE_W-1:0]   out_avg,
	output logic [iral_pkg::DIST_W-1:0]     out_dist,
	output logic                            out_gnd,
	output logic                            out_beyond
);
	import iral_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SUB  = 10'b0000000010,
		S_ADD  = 10'b0000000100,
		S_GND  = 10'b0000001000,
		S_SRCH = 10'b0000010000,
		S_SPAN = 10'b0000100000,
		S_PART = 10'b0001000000,
		S_MUL5 = 10'b0010000000,
		S_DIV  = 10'b0100000000,
		S_FIN  = 10'b1000000000
	} state_t;

	localparam logic [CHAN_FW:0]   CH_LIM   = (CHAN_FW+1)'(CHANNELS);
	localparam logic [WIN_W-1:0]   POS_LAST = WIN_W'(WINDOW - 1);
	localparam logic [J_W-1:0]     J_LAST   = J_W'(CURVE_POINTS - 1);

	state_t              state_q;
	logic [CH_W-1:0]     ch_q;
	logic [CHAN_FW-1:0]  ch_full_q;
	logic [SAMPLE_W-1:0] raw_q;
	logic [SUM_W-1:0]    sum_q [CHANNELS];
	logic [WIN_W-1:0]    pos_q [CHANNELS];
	logic [ALU_W-1:0]    tmp_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W-1:0] span_q;
	logic [J_W-1:0]      j_q;
	logic [DIST_W-1:0]   d0_q;
	logic [2:0]          quo_q;
	logic [1:0]          k_q;
	logic                gnd_q;
	logic                beyond_q;

	logic                out_valid_q;
	logic [CHAN_FW-1:0]  out_ch_q;
	logic [SAMPLE_W-1:0] out_avg_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_gnd_q;
	logic                out_beyond_q;

	logic                accept;
	logic                chan_ok;
	logic [CH_W-1:0]     in_idx;
	logic [SAMPLE_W-1:0] old_sample;
	alu_req_t            alu_req;
	logic [ALU_W-1:0]    alu_res;
	logic                alu_ge;
	logic                out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign chan_ok  = ({1'b0, in_ch} < CH_LIM);
	assign in_idx   = in_ch[CH_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	iral_ring_ram u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept && chan_ok),
		.addr   ({in_idx, pos_q[in_idx]}),
		.wdata  (in_raw),
		.rdata  (old_sample)
	);

	iral_alu u_alu (
		.req (alu_req),
		.res (alu_res),
		.ge  (alu_ge)
	);

	always_comb begin
		alu_req = '0;
		case (state_q)
			S_SUB: begin
				alu_req.a   = ALU_W'(sum_q[ch_q]);
				alu_req.b   = ALU_W'(old_sample);
				alu_req.sub = 1'b1;
			end
			S_ADD: begin
				alu_req.a = tmp_q;
				alu_req.b = ALU_W'(raw_q);
			end
			S_GND: begin
				alu_req.a   = ALU_W'(gnd_level);
				alu_req.b   = ALU_W'(avg_q);
				alu_req.sub = 1'b1;
			end
			S_SRCH, S_SPAN: begin
				alu_req.a   = (state_q == S_SRCH) ? ALU_W'(avg_q) : ALU_W'(hi_q);
				alu_req.b   = ALU_W'(CURVE[j_q]);
				alu_req.sub = 1'b1;
			end
			S_PART: begin
				alu_req.a   = ALU_W'(hi_q);
				alu_req.b   = ALU_W'(avg_q);
				alu_req.sub = 1'b1;
			end
			S_MUL5: begin
				alu_req.a = tmp_q << 2;
				alu_req.b = tmp_q;
			end
			S_DIV: begin
				alu_req.a   = tmp_q;
				alu_req.b   = ALU_W'(span_q) << k_q;
				alu_req.sub = 1'b1;
			end
			S_FIN: begin
				alu_req.a = ALU_W'(d0_q);
				alu_req.b = ALU_W'(quo_q);
			end
			default: alu_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c] <= '0;
				pos_q[c] <= '0;
			end
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (chan_ok) begin
							pos_q[in_idx] <= (pos_q[in_idx] == POS_LAST) ? '0
								: pos_q[in_idx] + 1'b1;
							state_q <= S_SUB;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SUB: state_q <= S_ADD;
				S_ADD: begin
					sum_q[ch_q] <= alu_res[SUM_W-1:0];
					state_q     <= gnd_q ? S_GND : S_SRCH;
				end
				S_GND: state_q <= S_FIN;
				S_SRCH: begin
					if (alu_ge || j_q == J_LAST) begin
						state_q <= (alu_ge && j_q != '0) ? S_SPAN : S_FIN;
					end
				end
				S_SPAN: state_q <= (alu_res[SAMPLE_W-1:0] == '0) ? S_FIN : S_PART;
				S_PART: state_q <= S_MUL5;
				S_MUL5: state_q <= S_DIV;
				S_DIV: begin
					if (k_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ch_q      <= in_idx;
				ch_full_q <= in_ch;
				raw_q     <= in_raw;
				j_q       <= '0;
				d0_q      <= '0;
				quo_q     <= '0;
				k_q       <= 2'd2;
				avg_q     <= '0;
				gnd_q     <= chan_ok ? gnd_mask[in_ch] : 1'b0;
				beyond_q  <= 1'b0;
			end
			S_SUB: tmp_q <= alu_res;
			S_ADD: avg_q <= alu_res[WIN_W +: SAMPLE_W];
			S_GND: d0_q  <= DIST_W'(alu_ge);
			S_SRCH: begin
				if (alu_ge) begin
					if (j_q == '0) begin
						d0_q <= STEP_D;
					end
				end else if (j_q == J_LAST) begin
					d0_q     <= BEYOND_MM;
					beyond_q <= 1'b1;
				end else begin
					hi_q <= CURVE[j_q];
					d0_q <= d0_q + STEP_D;
					j_q  <= j_q + 1'b1;
				end
			end
			S_SPAN: span_q <= alu_res[SAMPLE_W-1:0];
			S_PART, S_MUL5: tmp_q <= alu_res;
			S_DIV: begin
				if (alu_ge) begin
					tmp_q      <= alu_res;
					quo_q[k_q] <= 1'b1;
				end
				k_q <= k_q - 1'b1;
			end
			S_FIN: begin
				if (out_free) begin
					out_ch_q     <= ch_full_q;
					out_avg_q    <= avg_q;
					out_dist_q   <= alu_res[DIST_W-1:0];
					out_gnd_q    <= gnd_q;
					out_beyond_q <= beyond_q;
				end
			end
			default: tmp_q <= tmp_q;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_ch     = out_ch_q;
	assign out_avg    = out_avg_q;
	assign out_dist   = out_dist_q;
	assign out_gnd    = out_gnd_q;
	assign out_beyond = out_beyond_q;

	`IRAL_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, state_q != S_IDLE)
	`IRAL_ASSERT(a_search_bound, clk, arst_n, (state_q == S_SRCH) |-> (j_q <= J_LAST))
	`IRAL_ASSERT(a_beyond_sat, clk, arst_n, (out_valid_q && out_beyond_q) |-> (out_dist_q == BEYOND_MM && !out_gnd_q))
	`IRAL_ASSERT(a_ground_flag, clk, arst_n, (out_valid_q && out_gnd_q) |-> (out_dist_q <= DIST_W'(1)))

endmodule

// ----- sv/ir_range_average_and_linearize_top.sv -----
`timescale 1ns / 1ps
// Infrared range front end: each sample transaction updates its channel's 16-deep boxcar
// average, then either compares it with the ground level (channels set in the ground mask)
// or walks the 30-point calibration curve one point a cycle and interpolates to millimetres
// with a 3-step restoring division. The boxcar update, the ground and curve compares and the
// interpolation all run through one shared adder/subtractor, so the work on an item is
// dominated by the serial curve search; s_tready is low while an item is being worked on,
// and a finished result sits in the output register until taken. The sample history reads
// as zero after reset through per-entry valid bits, so no clearing pass is needed.
// Configuration index 0 is the ground channel mask, index 1 the ground level.

module ir_range_average_and_linearize_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // raw_sample[11:0], zero pad [15:12]
	input  logic [2:0]  s_tuser,   // channel[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // average[11:0], distance_mm[19:12], zero pad [23:20]
	output logic [4:0]  m_tuser,   // channel_out[2:0], is_ground[3], beyond_curve[4]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_data
);
	import iral_pkg::*;

	logic [MASK_W-1:0]   gnd_mask_q;
	logic [SAMPLE_W-1:0] gnd_level_q;
	logic [CHAN_FW-1:0]  out_ch;
	logic [SAMPLE_W-1:0] out_avg;
	logic [DIST_W-1:0]   out_dist;
	logic                out_gnd;
	logic                out_beyond;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gnd_mask_q  <= MASK_W'(136);
			gnd_level_q <= SAMPLE_W'(3800);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				CFG_GND_MASK:  gnd_mask_q  <= cfg_data[MASK_W-1:0];
				CFG_GND_LEVEL: gnd_level_q <= cfg_data[SAMPLE_W-1:0];
				default:       gnd_mask_q  <= gnd_mask_q;
			endcase
		end
	end

	iral_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_ch      (s_tuser[CHAN_FW-1:0]),
		.in_raw     (s_tdata[SAMPLE_W-1:0]),
		.gnd_mask   (gnd_mask_q),
		.gnd_level  (gnd_level_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_ch     (out_ch),
		.out_avg    (out_avg),
		.out_dist   (out_dist),
		.out_gnd    (out_gnd),
		.out_beyond (out_beyond)
	);

	assign m_tdata = {4'b0000, out_dist, out_avg};
	assign m_tuser = {out_beyond, out_gnd, out_ch};

endmodule
